@@ rtl/epfc_pkg.sv @@
package epfc_pkg;

    // CORDIC micro-rotation count; steps beyond 24 are not used
    localparam int CORDIC_STEPS = 16;
    localparam int NUM_CELLS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    localparam int STEP_W = 5;

    localparam int XW = 34;     // Q4.30 rotation vector, angle accumulator in 2^-32 turns
    localparam int PW = 65;     // column times half-size product
    localparam logic signed [XW-1:0] CORDIC_K = 34'sd652032874;

    typedef struct packed {
        logic [1:0]             q;
        logic signed [XW-1:0]   x;
        logic signed [XW-1:0]   y;
        logic signed [XW-1:0]   z;
    } lane_t;

    typedef struct packed {
        logic                   valid;
        lane_t [2:0]            lane;   // 0 roll, 1 pitch, 2 yaw
        logic [2:0][31:0]       pos;
    } cell_t;

    typedef struct packed {
        logic                   valid;
        logic [2:0][PW-1:0]     a;      // col0 * width
        logic [2:0][PW-1:0]     b;      // col2 * length
        logic [2:0][31:0]       pos;
    } mat_t;

    // arctangent of 2^-i in 2^-32 turn units
    function automatic logic signed [XW-1:0] atan_step(input logic [STEP_W-1:0] i);
        logic signed [XW-1:0] v;
        begin
            case (i)
                5'd0:  v = 34'sd536870912;
                5'd1:  v = 34'sd316933406;
                5'd2:  v = 34'sd167458907;
                5'd3:  v = 34'sd85004756;
                5'd4:  v = 34'sd42667331;
                5'd5:  v = 34'sd21354465;
                5'd6:  v = 34'sd10679838;
                5'd7:  v = 34'sd5340245;
                5'd8:  v = 34'sd2670163;
                5'd9:  v = 34'sd1335087;
                5'd10: v = 34'sd667544;
                5'd11: v = 34'sd333772;
                5'd12: v = 34'sd166886;
                5'd13: v = 34'sd83443;
                5'd14: v = 34'sd41722;
                5'd15: v = 34'sd20861;
                5'd16: v = 34'sd10430;
                5'd17: v = 34'sd5215;
                5'd18: v = 34'sd2608;
                5'd19: v = 34'sd1304;
                5'd20: v = 34'sd652;
                5'd21: v = 34'sd326;
                5'd22: v = 34'sd163;
                5'd23: v = 34'sd81;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

@@ rtl/epfc_cordic_cell.sv @@
module epfc_cordic_cell (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [epfc_pkg::STEP_W-1:0]        step,
    input  epfc_pkg::cell_t                    d_in,
    output epfc_pkg::cell_t                    d_out
);

    logic                          valid_reg;
    epfc_pkg::lane_t [2:0]         lane_reg;
    logic [2:0][31:0]              pos_reg;
    epfc_pkg::cell_t               cell_next;

    // one micro-rotation on each of the three angle lanes
    always_comb
    begin
        logic signed [epfc_pkg::XW-1:0] dx;
        logic signed [epfc_pkg::XW-1:0] dy;
        logic signed [epfc_pkg::XW-1:0] at;
        cell_next = d_in;
        at = epfc_pkg::atan_step(step);
        for (int k = 0; k < 3; k++)
        begin
            dx = d_in.lane[k].y >>> step;
            dy = d_in.lane[k].x >>> step;
            if (!d_in.lane[k].z[epfc_pkg::XW-1])
            begin
                cell_next.lane[k].x = d_in.lane[k].x - dx;
                cell_next.lane[k].y = d_in.lane[k].y + dy;
                cell_next.lane[k].z = d_in.lane[k].z - at;
            end
            else
            begin
                cell_next.lane[k].x = d_in.lane[k].x + dx;
                cell_next.lane[k].y = d_in.lane[k].y - dy;
                cell_next.lane[k].z = d_in.lane[k].z + at;
            end
        end
    end

    // advance valid; load payload only with an item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= d_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_in.valid)
        begin
            lane_reg <= cell_next.lane;
            pos_reg  <= cell_next.pos;
        end
    end

    assign d_out = {valid_reg, lane_reg, pos_reg};

endmodule

@@ rtl/epfc_rot_matrix.sv @@
module epfc_rot_matrix (
    input  logic                 clk,
    input  logic                 rst_n,
    input  epfc_pkg::cell_t      d_in,
    input  logic [30:0]          body_width,
    input  logic [30:0]          body_length,
    output epfc_pkg::mat_t       m_out
);

    // stage 1: quadrant fix, round to Q1.15
    logic                      s1_valid_reg;
    logic signed [15:0]        cs_reg [3];
    logic signed [15:0]        sn_reg [3];
    logic [2:0][31:0]          s1_pos_reg;
    logic signed [15:0]        cs_next [3];
    logic signed [15:0]        sn_next [3];

    function automatic logic signed [15:0] rnd15(input logic signed [epfc_pkg::XW:0] v);
        logic signed [epfc_pkg::XW+1:0] t;
        logic signed [epfc_pkg::XW-14:0] s;
        begin
            t = $signed({v[epfc_pkg::XW], v}) + 36'sd16384;
            s = t[epfc_pkg::XW+1:15];
            if (s > 21'sd32767)
                return 16'sh7FFF;
            else if (s < -21'sd32768)
                return 16'sh8000;
            else
                return s[15:0];
        end
    endfunction

    always_comb
    begin
        logic signed [epfc_pkg::XW:0] vx;
        logic signed [epfc_pkg::XW:0] vy;
        for (int k = 0; k < 3; k++)
        begin
            vx = 35'(d_in.lane[k].x);
            vy = 35'(d_in.lane[k].y);
            case (d_in.lane[k].q)
                2'd0:
                begin
                    cs_next[k] = rnd15(vx);
                    sn_next[k] = rnd15(vy);
                end
                2'd1:
                begin
                    cs_next[k] = rnd15(-vy);
                    sn_next[k] = rnd15(vx);
                end
                2'd2:
                begin
                    cs_next[k] = rnd15(-vx);
                    sn_next[k] = rnd15(-vy);
                end
                default:
                begin
                    cs_next[k] = rnd15(vy);
                    sn_next[k] = rnd15(-vx);
                end
            endcase
        end
    end

    // stage 2: pairwise products
    logic                      s2_valid_reg;
    logic signed [31:0]        p_czcy_reg, p_szcy_reg, p_czsy_reg, p_szsy_reg;
    logic signed [31:0]        p_szsx_reg, p_czsx_reg, p_cycx_reg;
    logic signed [15:0]        s2_cx_reg, s2_sy_reg;
    logic [2:0][31:0]          s2_pos_reg;

    // stage 3: columns 0 and 2 in Q29
    logic                      s3_valid_reg;
    logic signed [32:0]        c0_reg [3];
    logic signed [32:0]        c2_reg [3];
    logic [2:0][31:0]          s3_pos_reg;
    logic signed [32:0]        c0_next [3];
    logic signed [32:0]        c2_next [3];

    always_comb
    begin
        logic signed [48:0] t0;
        logic signed [48:0] t1;
        logic signed [32:0] r;
        c0_next[0] = 33'(($signed({p_czcy_reg[31], p_czcy_reg}) + 33'sd1) >>> 1);
        c0_next[1] = 33'(($signed({p_szcy_reg[31], p_szcy_reg}) + 33'sd1) >>> 1);
        c0_next[2] = -($signed(33'(s2_sy_reg)) <<< 14);
        t0 = 49'(p_czsy_reg) * 49'(s2_cx_reg) + (49'(p_szsx_reg) <<< 15) + 49'sd32768;
        t1 = 49'(p_szsy_reg) * 49'(s2_cx_reg) - (49'(p_czsx_reg) <<< 15) + 49'sd32768;
        c2_next[0] = t0[48:16];
        c2_next[1] = t1[48:16];
        r = 33'(($signed({p_cycx_reg[31], p_cycx_reg}) + 33'sd1) >>> 1);
        c2_next[2] = r;
    end

    // stage 4: scale by the body size
    logic                          m_valid_reg;
    logic [2:0][epfc_pkg::PW-1:0]  m_a_reg;
    logic [2:0][epfc_pkg::PW-1:0]  m_b_reg;
    logic [2:0][31:0]              m_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= d_in.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            m_valid_reg  <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_in.valid)
        begin
            cs_reg     <= cs_next;
            sn_reg     <= sn_next;
            s1_pos_reg <= d_in.pos;
        end
        if (s1_valid_reg)
        begin
            p_czcy_reg <= cs_reg[2] * cs_reg[1];
            p_szcy_reg <= sn_reg[2] * cs_reg[1];
            p_czsy_reg <= cs_reg[2] * sn_reg[1];
            p_szsy_reg <= sn_reg[2] * sn_reg[1];
            p_szsx_reg <= sn_reg[2] * sn_reg[0];
            p_czsx_reg <= cs_reg[2] * sn_reg[0];
            p_cycx_reg <= cs_reg[1] * cs_reg[0];
            s2_cx_reg  <= cs_reg[0];
            s2_sy_reg  <= sn_reg[1];
            s2_pos_reg <= s1_pos_reg;
        end
        if (s2_valid_reg)
        begin
            c0_reg     <= c0_next;
            c2_reg     <= c2_next;
            s3_pos_reg <= s2_pos_reg;
        end
        if (s3_valid_reg)
        begin
            for (int k = 0; k < 3; k++)
            begin
                m_a_reg[k] <= c0_reg[k] * $signed({1'b0, body_width});
                m_b_reg[k] <= c2_reg[k] * $signed({1'b0, body_length});
            end
            m_pos_reg <= s3_pos_reg;
        end
    end

    assign m_out = {m_valid_reg, m_a_reg, m_b_reg, m_pos_reg};

endmodule

@@ rtl/euler_pose_frame_corners.sv @@
// Channel  | Handshake               | Payload
// ---------+-------------------------+---------------------------------------------
// pose in  | start, busy             | roll/pitch/yaw_angle, pos_x/y/z
// corners  | result_valid            | corner_id, world_x/y/z, last_corner
// config   | cfg_we, cfg_addr        | cfg_data (0 body_width, 1 body_length)
//
// After each accepted item busy stays high until its down counter runs out,
// and the four corners of the item leave one per cycle.
// The first corner reaches the registered outputs after passing the chain
// of CORDIC cells and the four matrix stages.
// Reset clears all valid and count state; the corner outputs cannot be stalled.
module euler_pose_frame_corners (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  logic [15:0]  roll_angle,
    input  logic [15:0]  pitch_angle,
    input  logic [15:0]  yaw_angle,
    input  logic [31:0]  pos_x,
    input  logic [31:0]  pos_y,
    input  logic [31:0]  pos_z,
    input  logic         cfg_we,
    input  logic         cfg_addr,
    input  logic [30:0]  cfg_data,
    output logic         result_valid,
    output logic [1:0]   corner_id,
    output logic [31:0]  world_x,
    output logic [31:0]  world_y,
    output logic [31:0]  world_z,
    output logic         last_corner
);

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_LENGTH = 1'b1;

    logic [30:0] width_reg;
    logic [30:0] length_reg;
    logic [1:0]  busy_reg;
    logic        accept;

    assign accept = start && !busy;
    assign busy   = (busy_reg != 2'd0);

    // hold the body size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            length_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_LENGTH: length_reg <= cfg_data;
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    // hold busy after each accepted item until the down counter reaches zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 2'd0;
        else if (accept)
            busy_reg <= 2'd3;
        else if (busy_reg != 2'd0)
            busy_reg <= busy_reg - 2'd1;
    end

    // split each angle into quadrant and residual, seed the chain
    epfc_pkg::cell_t chain [epfc_pkg::NUM_CELLS+1];
    epfc_pkg::cell_t seed;

    always_comb
    begin
        logic [15:0] ang [3];
        logic [15:0] t;
        logic [1:0]  q;
        ang[0] = roll_angle;
        ang[1] = pitch_angle;
        ang[2] = yaw_angle;
        seed.valid = accept;
        for (int k = 0; k < 3; k++)
        begin
            t = ang[k] + 16'd8192;
            q = t[15:14];
            seed.lane[k].q = q;
            seed.lane[k].x = epfc_pkg::CORDIC_K;
            seed.lane[k].y = '0;
            seed.lane[k].z = ($signed({20'd0, t[13:0]}) - 34'sd8192) <<< 16;
        end
        seed.pos[0] = pos_x;
        seed.pos[1] = pos_y;
        seed.pos[2] = pos_z;
    end

    assign chain[0] = seed;

    genvar g;
    generate
        for (g = 0; g < epfc_pkg::NUM_CELLS; g++)
        begin : g_cell
            epfc_cordic_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .step  (epfc_pkg::STEP_W'(g)),
                .d_in  (chain[g]),
                .d_out (chain[g+1])
            );
        end
    endgenerate

    epfc_pkg::mat_t mat;

    epfc_rot_matrix u_mat (
        .clk         (clk),
        .rst_n       (rst_n),
        .d_in        (chain[epfc_pkg::NUM_CELLS]),
        .body_width  (width_reg),
        .body_length (length_reg),
        .m_out       (mat)
    );

    // emit the four corners, one per cycle
    logic        emit_reg;
    logic [1:0]  cnt_reg;
    logic        emit_now;
    logic [1:0]  k_now;

    assign emit_now = mat.valid || emit_reg;
    assign k_now    = mat.valid ? 2'd0 : cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_reg     <= 1'b0;
            cnt_reg      <= 2'd0;
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= emit_now;
            if (emit_now)
            begin
                cnt_reg  <= k_now + 2'd1;
                emit_reg <= (k_now != 2'd3);
            end
        end
    end

    logic [31:0] wv_next [3];

    always_comb
    begin
        logic signed [66:0] s;
        logic signed [36:0] v;
        for (int j = 0; j < 3; j++)
        begin
            s = (k_now[0] ? 67'($signed(mat.a[j])) : -67'($signed(mat.a[j])))
              + (k_now[1] ? 67'($signed(mat.b[j])) : -67'($signed(mat.b[j])))
              + 67'sd536870912;
            v = 37'(s >>> 30) + 37'($signed(mat.pos[j]));
            if (v > 37'sd2147483647)
                wv_next[j] = 32'h7FFF_FFFF;
            else if (v < -37'sd2147483648)
                wv_next[j] = 32'h8000_0000;
            else
                wv_next[j] = v[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_now)
        begin
            corner_id   <= k_now;
            world_x     <= wv_next[0];
            world_y     <= wv_next[1];
            world_z     <= wv_next[2];
            last_corner <= (k_now == 2'd3);
        end
    end

endmodule

@@ rtl/epfc_checker.sv @@
module epfc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        result_valid,
    input  logic [1:0]  corner_id,
    input  logic        last_corner
);

    // an accepted item blocks the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    // last flag only on corner three
    a_last_id: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_corner |-> corner_id == 2'd3)
        else $error("last corner flag on wrong corner");

    // corners of one item arrive in consecutive cycles
    a_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && corner_id != 2'd3 |=> result_valid
            && corner_id == $past(corner_id) + 2'd1)
        else $error("corner run broken");

    // a run starts at corner zero
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> corner_id == 2'd0)
        else $error("corner run starts mid way");

endmodule

bind euler_pose_frame_corners epfc_checker u_epfc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .corner_id    (corner_id),
    .last_corner  (last_corner)
);

@@ dv/euler_pose_frame_corners_chk.sv @@
`timescale 1ns / 100ps

module euler_pose_frame_corners_chk (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         busy,
    input  logic [15:0]  roll_angle,
    input  logic [15:0]  pitch_angle,
    input  logic [15:0]  yaw_angle,
    input  logic [31:0]  pos_x,
    input  logic [31:0]  pos_y,
    input  logic [31:0]  pos_z,
    input  logic         cfg_we,
    input  logic         cfg_addr,
    input  logic [30:0]  cfg_data,
    input  logic         result_valid,
    input  logic [1:0]   corner_id,
    input  logic [31:0]  world_x,
    input  logic [31:0]  world_y,
    input  logic [31:0]  world_z,
    input  logic         last_corner,
    output int           errors,
    output int           pending
);

    localparam logic ADDR_WIDTH  = 1'b0;
    localparam logic ADDR_LENGTH = 1'b1;

    typedef struct packed {
        logic [1:0]  id;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        last;
    } corner_t;

    corner_t expected_corners[$];
    longint  width_q;
    longint  length_q;

    // floor of v / 2^s after adding one half
    function automatic longint rnd_shift(input longint v, input int s);
        longint half;
        begin
            half = longint'(1) <<< (s - 1);
            return (v + half) >>> s;
        end
    endfunction

    function automatic longint sat_q15(input longint v);
        begin
            if (v > 32767)
                return 32767;
            if (v < -32768)
                return -32768;
            return v;
        end
    endfunction

    // Q1.15 cosine and sine from quadrant fold plus CORDIC on the residual
    function automatic void cordic_sincos(input logic [15:0] a, output longint c,
                                          output longint s);
        longint q, r, x, y, z, dx, dy, cx, sy;
        int     i;
        begin
            q = ((longint'(a) + 8192) >> 14) & 3;
            r = ((longint'(a) + 262144 - q * 16384 + 8192) & 64'hFFFF) - 8192;
            z = r * 65536;
            x = 652032874;
            y = 0;
            for (i = 0; i < epfc_pkg::NUM_CELLS; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - longint'(epfc_pkg::atan_step(i[4:0]));
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + longint'(epfc_pkg::atan_step(i[4:0]));
                end
            end
            case (q)
                0: begin cx = x;  sy = y;  end
                1: begin cx = -y; sy = x;  end
                2: begin cx = -x; sy = -y; end
                default: begin cx = y; sy = -x; end
            endcase
            c = sat_q15(rnd_shift(cx, 15));
            s = sat_q15(rnd_shift(sy, 15));
        end
    endfunction

    // Rotate the four frame corners and queue them in output order
    function automatic void predict_corners();
        longint  cr, sr, cp, sp, cw, sw, hx, hz, v;
        longint  col0[3], col2[3], pos[3];
        corner_t c;
        logic [31:0] coord[3];
        int      k, j;
        begin
            cordic_sincos(roll_angle, cr, sr);
            cordic_sincos(pitch_angle, cp, sp);
            cordic_sincos(yaw_angle, cw, sw);
            pos[0] = longint'($signed(pos_x));
            pos[1] = longint'($signed(pos_y));
            pos[2] = longint'($signed(pos_z));
            col0[0] = rnd_shift(cw * cp * 32768, 16);
            col0[1] = rnd_shift(sw * cp * 32768, 16);
            col0[2] = rnd_shift(-sp * 1073741824, 16);
            col2[0] = rnd_shift(cw * sp * cr + sw * sr * 32768, 16);
            col2[1] = rnd_shift(sw * sp * cr - cw * sr * 32768, 16);
            col2[2] = rnd_shift(cp * cr * 32768, 16);
            for (k = 0; k < 4; k++)
            begin
                hx = (k & 1) ? width_q : -width_q;
                hz = (k & 2) ? length_q : -length_q;
                for (j = 0; j < 3; j++)
                begin
                    v = rnd_shift(col0[j] * hx + col2[j] * hz, 30) + pos[j];
                    if (v > 64'sd2147483647)
                        v = 64'sd2147483647;
                    if (v < -64'sd2147483648)
                        v = -64'sd2147483648;
                    coord[j] = v[31:0];
                end
                c.id   = k[1:0];
                c.x    = coord[0];
                c.y    = coord[1];
                c.z    = coord[2];
                c.last = (k == 3);
                expected_corners.push_back(c);
            end
        end
    endfunction

    function automatic void cmp_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
        begin
            if (exp_v !== got_v)
            begin
                $display("%0t mismatch %s expected %h actual %h", $time, name, exp_v, got_v);
                errors++;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        corner_t e;
        if (!rst_n)
        begin
            width_q  = 0;
            length_q = 0;
            errors   = 0;
            expected_corners.delete();
            pending  = 0;
        end
        else
        begin
            // check corner against oldest expectation
            if (result_valid)
            begin
                if (expected_corners.size() == 0)
                begin
                    $display("%0t unexpected corner id %0d x %h", $time, corner_id, world_x);
                    errors++;
                end
                else
                begin
                    e = expected_corners.pop_front();
                    cmp_field("corner_id", 32'(e.id), 32'(corner_id));
                    cmp_field("world_x", e.x, world_x);
                    cmp_field("world_y", e.y, world_y);
                    cmp_field("world_z", e.z, world_z);
                    cmp_field("last_corner", 32'(e.last), 32'(last_corner));
                end
            end
            // predict from accepted pose
            if (start && !busy)
                predict_corners();
            pending = expected_corners.size();
            // track register writes
            if (cfg_we)
            begin
                if (cfg_addr == ADDR_WIDTH)
                    width_q = longint'(cfg_data);
                else if (cfg_addr == ADDR_LENGTH)
                    length_q = longint'(cfg_data);
            end
        end
    end

endmodule

@@ dv/euler_pose_frame_corners_tb.sv @@
`timescale 1ns / 100ps

module euler_pose_frame_corners_tb;

    localparam int  DRAIN     = epfc_pkg::NUM_CELLS + 12;
    localparam int  LIMIT     = 400000;
    localparam logic ADDR_WIDTH  = 1'b0;
    localparam logic ADDR_LENGTH = 1'b1;
    localparam logic [30:0] SIZE_MAX = 31'h7FFFFFFF;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] roll_angle = '0;
    logic [15:0] pitch_angle = '0;
    logic [15:0] yaw_angle = '0;
    logic [31:0] pos_x = '0;
    logic [31:0] pos_y = '0;
    logic [31:0] pos_z = '0;
    logic        cfg_we = 1'b0;
    logic        cfg_addr = 1'b0;
    logic [30:0] cfg_data = '0;
    logic        result_valid;
    logic [1:0]  corner_id;
    logic [31:0] world_x;
    logic [31:0] world_y;
    logic [31:0] world_z;
    logic        last_corner;
    int          errors;
    int          pending;
    int          cycles = 0;
    int          idle_pct = 0;

    euler_pose_frame_corners u_top (.*);

    euler_pose_frame_corners_chk u_chk (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    // hard stop on a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("FAIL euler_pose_frame_corners");
            $finish;
        end
    end

    // hold until every corner is out, then let the pipeline settle
    task automatic wait_empty();
        begin
            while (pending != 0)
                @(posedge clk);
            repeat (DRAIN) @(posedge clk);
        end
    endtask

    task automatic set_size(input logic [30:0] w, input logic [30:0] l);
        begin
            start <= 1'b0;
            wait_empty();
            cfg_we   <= 1'b1;
            cfg_addr <= ADDR_WIDTH;
            cfg_data <= w;
            @(posedge clk);
            cfg_addr <= ADDR_LENGTH;
            cfg_data <= l;
            @(posedge clk);
            cfg_we   <= 1'b0;
        end
    endtask

    // offer one pose item and hold it until accepted
    task automatic send_pose(input logic [15:0] r, input logic [15:0] p,
                             input logic [15:0] y, input logic [31:0] px,
                             input logic [31:0] py, input logic [31:0] pz);
        begin
            if (idle_pct > 0 && $urandom_range(99) < idle_pct)
            begin
                start <= 1'b0;
                @(posedge clk);
                while ($urandom_range(99) < idle_pct)
                    @(posedge clk);
            end
            start       <= 1'b1;
            roll_angle  <= r;
            pitch_angle <= p;
            yaw_angle   <= y;
            pos_x       <= px;
            pos_y       <= py;
            pos_z       <= pz;
            @(posedge clk);
            while (busy)
                @(posedge clk);
        end
    endtask

    function automatic logic [15:0] rand_angle();
        logic [15:0] edges[10];
        begin
            edges = '{16'd0, 16'd65535, 16'd8191, 16'd8192, 16'd16383,
                      16'd24575, 16'd24576, 16'd40959, 16'd57343, 16'd57344};
            if ($urandom_range(3) == 0)
                return edges[$urandom_range(9)] + 16'($urandom_range(2)) - 16'd1;
            return 16'($urandom_range(65535));
        end
    endfunction

    function automatic logic [31:0] rand_pos();
        begin
            case ($urandom_range(3))
                0: return 32'h7FFFFFFF - 32'($urandom_range(65535));
                1: return 32'h80000000 + 32'($urandom_range(65535));
                2: return 32'($signed($urandom_range(2000000)) - 1000000);
                default: return $urandom();
            endcase
        end
    endfunction

    function automatic logic [30:0] rand_size();
        begin
            case ($urandom_range(3))
                0: return SIZE_MAX - 31'($urandom_range(1023));
                1: return 31'($urandom_range(1048576));
                default: return 31'($urandom());
            endcase
        end
    endfunction

    initial
    begin
        int blk, n;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero size, then angle and position extremes
        send_pose(16'd0, 16'd0, 16'd0, 32'h0, 32'h0, 32'h0);
        set_size(31'h00030000, 31'h00050000);
        send_pose(16'd0, 16'd0, 16'd0, 32'h0, 32'h0, 32'h0);
        send_pose(16'd65535, 16'd65535, 16'd65535, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_pose(16'd8191, 16'd8192, 16'd16384, 32'h7FFFFFFF, 32'h80000000, 32'h0);
        send_pose(16'd16384, 16'd32768, 16'd49152, 32'h80000000, 32'h7FFFFFFF, 32'h1);
        send_pose(16'd24575, 16'd24576, 16'd57344, 32'h00010000, 32'hFFFF0000, 32'h0);
        send_pose(16'd32768, 16'd16384, 16'd8192, 32'h12345678, 32'hEDCBA987, 32'h55555555);
        send_pose(16'd49152, 16'd57343, 16'd40960, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA);
        set_size(SIZE_MAX, SIZE_MAX);
        send_pose(16'd0, 16'd0, 16'd0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        send_pose(16'd32768, 16'd0, 16'd16384, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        send_pose(16'd8192, 16'd8192, 16'd8192, 32'h0, 32'h0, 32'h0);
        send_pose(16'd57344, 16'd49152, 16'd24576, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
        set_size(31'd0, SIZE_MAX);
        send_pose(16'd4096, 16'd12288, 16'd20480, 32'h0, 32'h80000000, 32'h7FFFFFFF);
        set_size(SIZE_MAX, 31'd0);
        send_pose(16'd61440, 16'd53248, 16'd45056, 32'h7FFFFFFF, 32'h0, 32'h80000000);

        // random: six blocks, each with new sizes; idle rate 32, 74, then 0 percent, by pairs
        for (blk = 0; blk < 6; blk++)
        begin
            idle_pct = (blk < 2) ? 32 : ((blk < 4) ? 74 : 0);
            case (blk)
                0: set_size(31'd0, 31'd0);
                1: set_size(SIZE_MAX, SIZE_MAX);
                default: set_size(rand_size(), rand_size());
            endcase
            for (n = 0; n < 56; n++)
                send_pose(rand_angle(), rand_angle(), rand_angle(),
                          rand_pos(), rand_pos(), rand_pos());
        end
        start <= 1'b0;

        // drain and give the verdict
        wait_empty();
        if (errors == 0 && pending == 0)
            $display("PASS euler_pose_frame_corners");
        else
            $display("FAIL euler_pose_frame_corners");
        $finish;
    end

endmodule
